// File: src/nonzero_minmax_contrast_stretch_top_defines.svh
// Assertion macros used by the checker of the contrast stretch block.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef NONZERO_MINMAX_CONTRAST_STRETCH_TOP_DEFINES_SVH
`define NONZERO_MINMAX_CONTRAST_STRETCH_TOP_DEFINES_SVH

// Same-cycle implication.
`define NMCS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NMCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nmcs_pkg.sv
// ----------------------------------------------------------------------------
// nmcs_pkg
// Widths and fixed levels of the nonzero min/max contrast stretch block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmcs_pkg;

  localparam int PIX_W = 8;
  localparam int NUM_W = 2 * PIX_W;
  localparam int CNT_W = $clog2(PIX_W);

  localparam logic [PIX_W-1:0] OUT_MAX    = 8'd255;
  localparam logic [PIX_W-1:0] OUT_ZERO   = 8'd0;
  localparam logic [PIX_W-1:0] LOW_RESET  = 8'd255;
  localparam logic [PIX_W-1:0] HIGH_RESET = 8'd0;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_MAP     = 1'b1;

endpackage

// File: src/nonzero_minmax_contrast_stretch_top.sv
// ----------------------------------------------------------------------------
// nonzero_minmax_contrast_stretch_top
// Two-pass min/max contrast stretch over nonzero 8-bit pixels.
// ----------------------------------------------------------------------------
// Measure pixels: one per cycle while no map pixel is in flight, no result.
// Map pixels: after the input transfer the pixel passes a setup state, 8
//   bit-serial restoring division steps and a done state that loads the
//   result once the output register is free; the division steps are skipped
//   when the pixel is out of range, the range is flat or no statistics exist.
// A new map pixel is only taken after the previous result is loaded.
// Reset (rst_n low, synchronous): statistics to min 255 / max 0 / none seen,
//   pipeline idle, no result pending.
`timescale 1ns / 1ps

module nonzero_minmax_contrast_stretch_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic                      in_first,
  input  logic [nmcs_pkg::PIX_W-1:0] in_pixel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [nmcs_pkg::PIX_W-1:0] out_stretched
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Statistics of the current image.
  logic [nmcs_pkg::PIX_W-1:0] low_r, low_nxt;
  logic [nmcs_pkg::PIX_W-1:0] high_r, high_nxt;
  logic                       seen_r, seen_nxt;

  // Map pixel held for the setup cycle.
  logic [nmcs_pkg::PIX_W-1:0] pix_r, pix_nxt;

  // Divider: partial remainder, numerator low byte that turns into the
  // quotient one bit per step, divisor and step count.
  logic [nmcs_pkg::PIX_W-1:0] rem_r, rem_nxt;
  logic [nmcs_pkg::PIX_W-1:0] quo_r, quo_nxt;
  logic [nmcs_pkg::PIX_W-1:0] span_r, span_nxt;
  logic [nmcs_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [nmcs_pkg::PIX_W-1:0] out_data_r, out_data_nxt;

  logic                       in_xfer;
  logic                       out_free;

  // Measure-path working values.
  logic [nmcs_pkg::PIX_W-1:0] base_low, base_high;
  logic                       base_seen;

  // Setup and division step values.
  logic [nmcs_pkg::PIX_W-1:0] diff;
  logic [nmcs_pkg::NUM_W-1:0] num;
  logic [nmcs_pkg::PIX_W:0]   trial;
  logic [nmcs_pkg::PIX_W:0]   trial_sub;
  logic                       fits;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_stretched = out_data_r;
  // The output register can take a new value when empty or being drained.
  assign out_free      = !out_valid_r || out_ready;

  always_comb begin
    // Statistics seen by this measure pixel: cleared when it opens an image.
    base_low  = in_first ? nmcs_pkg::LOW_RESET  : low_r;
    base_high = in_first ? nmcs_pkg::HIGH_RESET : high_r;
    base_seen = in_first ? 1'b0 : seen_r;

    // 255 * (p - min) as (x << 8) - x.
    diff = pix_r - low_r;
    num  = {diff, {nmcs_pkg::PIX_W{1'b0}}} - {{nmcs_pkg::PIX_W{1'b0}}, diff};

    // One restoring step: bring down the next numerator bit.
    trial     = {rem_r, quo_r[nmcs_pkg::PIX_W-1]};
    trial_sub = trial - {1'b0, span_r};
    fits      = (trial >= {1'b0, span_r});

    state_nxt     = state_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    seen_nxt      = seen_r;
    pix_nxt       = pix_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    span_nxt      = span_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_kind == nmcs_pkg::KIND_MEASURE) begin
            low_nxt  = base_low;
            high_nxt = base_high;
            seen_nxt = base_seen;
            // Zero pixels never count.
            if (in_pixel != '0) begin
              if (!base_seen) begin
                low_nxt  = in_pixel;
                high_nxt = in_pixel;
                seen_nxt = 1'b1;
              end else begin
                if (in_pixel < base_low) begin
                  low_nxt = in_pixel;
                end
                if (in_pixel > base_high) begin
                  high_nxt = in_pixel;
                end
              end
            end
          end else begin
            pix_nxt   = in_pixel;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        span_nxt = high_r - low_r;
        // Numerator high byte is already below the span, so 8 steps suffice.
        rem_nxt  = num[nmcs_pkg::NUM_W-1:nmcs_pkg::PIX_W];
        quo_nxt  = num[nmcs_pkg::PIX_W-1:0];
        cnt_nxt  = '0;
        if (!seen_r || (pix_r < low_r)) begin
          // No statistics or below range: result is zero.
          quo_nxt   = nmcs_pkg::OUT_ZERO;
          state_nxt = ST_DONE;
        end else if (pix_r > high_r) begin
          quo_nxt   = nmcs_pkg::OUT_MAX;
          state_nxt = ST_DONE;
        end else if (high_r == low_r) begin
          // Flat range, pixel on it: result is zero.
          quo_nxt   = nmcs_pkg::OUT_ZERO;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = fits ? trial_sub[nmcs_pkg::PIX_W-1:0] : trial[nmcs_pkg::PIX_W-1:0];
        quo_nxt = {quo_r[nmcs_pkg::PIX_W-2:0], fits};
        cnt_nxt = cnt_r + nmcs_pkg::CNT_W'(1);
        if (cnt_r == {nmcs_pkg::CNT_W{1'b1}}) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the quotient until the output register frees up.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = quo_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_r       <= nmcs_pkg::LOW_RESET;
      high_r      <= nmcs_pkg::HIGH_RESET;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pix_r      <= pix_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    span_r     <= span_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: src/nmcs_checker.sv
// ----------------------------------------------------------------------------
// nmcs_checker
// Port-level checks on the contrast stretch block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nonzero_minmax_contrast_stretch_top_defines.svh"

module nmcs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic                       in_first,
  input logic [nmcs_pkg::PIX_W-1:0] in_pixel,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [nmcs_pkg::PIX_W-1:0] out_stretched
);

  logic map_xfer;
  logic meas_xfer;
  logic out_stall;

  assign map_xfer  = in_valid && in_ready && (in_kind == nmcs_pkg::KIND_MAP);
  assign meas_xfer = in_valid && in_ready && (in_kind == nmcs_pkg::KIND_MEASURE)
                     && (in_first || !in_first) && (in_pixel == in_pixel);
  assign out_stall = out_valid && !out_ready;

  `NMCS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_stretched), "result lost")
  `NMCS_ASSERT_NEXT(a_map_busy, map_xfer, !in_ready, "input taken while map pixel in flight")
  `NMCS_ASSERT_NEXT(a_map_no_early, map_xfer, !$rose(out_valid), "map result too early")
  `NMCS_ASSERT_NEXT(a_meas_silent, meas_xfer, !$rose(out_valid), "measure pixel gave a result")

endmodule

bind nonzero_minmax_contrast_stretch_top nmcs_checker u_nmcs_checker (.*);
